// ----- rtl/hall_six_step_commutator_defines.svh -----
// Assertion macros for the hall six-step commutator checker.
// Used only by the checker file; no other dependencies.
`ifndef HALL_SIX_STEP_COMMUTATOR_DEFINES_SVH
`define HALL_SIX_STEP_COMMUTATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define HSSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define HSSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hssc_pkg.sv -----
// Shared types, constants and lookup tables of the hall six-step commutator.
// No dependencies.
package hssc_pkg;

    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_TIME = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_TIME  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSES    = 2'd3;

    localparam logic [9:0]  LEAD_RESET = 10'd50;
    localparam logic [15:0] LOW_RESET  = 16'd800;
    localparam logic [7:0]  PPR_RESET  = 8'd30;

    localparam logic [2:0] HALL_RESET     = 3'b101;
    localparam logic [2:0] SECTOR_INVALID = 3'd7;
    localparam logic [5:0] ALL_FLOAT      = 6'h2A;

    localparam logic [1:0] PHASE_LEAD  = 2'd0;
    localparam logic [1:0] PHASE_DRIVE = 2'd1;
    localparam logic [1:0] PHASE_LOW   = 2'd2;

    localparam int          DIV_STEPS       = 30;
    localparam int          DIV_CNT_W       = $clog2(DIV_STEPS);
    localparam logic [29:0] SPEED_NUMERATOR = 30'd600000000;
    localparam logic [24:0] SPEED_MAX       = 25'h1FFFFFF;

    typedef struct packed {
        logic accept;
        logic load_div;
        logic div_step;
        logic div_done;
        logic emit;
    } hssc_cmd_t;

    typedef struct packed {
        logic close_meas;
    } hssc_status_t;

    // Sector for hall pattern h1h2h3; SECTOR_INVALID for 000 and 111.
    function automatic logic [2:0] sector_lookup(input logic reverse, input logic [2:0] pat);
        logic [2:0] s;
        s = SECTOR_INVALID;
        if (!reverse) begin
            case (pat)
                3'd1: s = 3'd1;
                3'd2: s = 3'd3;
                3'd3: s = 3'd2;
                3'd4: s = 3'd5;
                3'd5: s = 3'd0;
                3'd6: s = 3'd4;
                default: s = SECTOR_INVALID;
            endcase
        end else begin
            case (pat)
                3'd1: s = 3'd4;
                3'd2: s = 3'd0;
                3'd3: s = 3'd5;
                3'd4: s = 3'd2;
                3'd5: s = 3'd3;
                3'd6: s = 3'd1;
                default: s = SECTOR_INVALID;
            endcase
        end
        return s;
    endfunction

    // Gate pattern A1,A2,B1,B2,C1,C2 driven in a sector.
    function automatic logic [5:0] drive_pattern(input logic [2:0] sec);
        logic [5:0] g;
        case (sec)
            3'd0: g = 6'h38;
            3'd1: g = 6'h2C;
            3'd2: g = 6'h0E;
            3'd3: g = 6'h0B;
            3'd4: g = 6'h23;
            3'd5: g = 6'h32;
            default: g = ALL_FLOAT;
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/hssc_ctrl.sv -----
// Controller of the hall six-step commutator: sequences accept, speed division and output.
// Depends on hssc_pkg.
module hssc_ctrl import hssc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  hssc_status_t status,
    output hssc_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = status.close_meas ? ST_MUL : ST_EMIT;
                end
            end
            ST_MUL: begin
                cmd.load_div = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.div_done = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/hssc_datapath.sv -----
// Datapath of the hall six-step commutator: settings, hall edge logic, phase timer,
// period count, bit-serial speed divider and output register. Depends on hssc_pkg.
module hssc_datapath import hssc_pkg::*; #(
    parameter int POSITION_WIDTH = 32,
    parameter int PERIOD_WIDTH   = 32,
    parameter int TIMER_WIDTH    = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [IN_DATA_W-1:0]   s_data,
    input  hssc_cmd_t              cmd,
    output hssc_status_t           status,
    output logic [OUT_DATA_W-1:0]  out_data,
    output logic                   out_updated
);

    localparam int DIVW = PERIOD_WIDTH + 8;
    localparam int CMPW = (DIVW > DIV_STEPS + 1) ? DIVW : DIV_STEPS + 1;

    // settings
    logic        dir_reg;
    logic [9:0]  lead_reg;
    logic [15:0] low_reg;
    logic [7:0]  ppr_reg;

    // commutation state
    logic [2:0]                hall_reg, hall_next;
    logic [2:0]                sector_reg, sector_next;
    logic [1:0]                phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]    remain_reg, remain_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic                      meas_reg, meas_next;
    logic [PERIOD_WIDTH-1:0]   period_reg, period_next;
    logic                      updated_reg, updated_next;
    logic [24:0]               speed_reg;

    // divider
    logic [DIVW-1:0]      divisor_reg;
    logic [DIV_STEPS-1:0] rem_reg, quo_reg;
    logic [DIV_STEPS:0]   rem_shift;
    logic [CMPW-1:0]      rem_diff;
    logic                 rem_ge;

    // output register
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_updated_reg;

    logic                   h1, h2, h3;
    logic [10:0]            high_time;
    logic                   e1, e2, e3, any_edge;
    logic [2:0]             pat1, pat2, pat3;
    logic [2:0]             sec1, sec2, sec3, lk1, lk2, lk3;
    logic [2:0]             pos_delta;
    logic [PERIOD_WIDTH-1:0] period_inc;
    logic [TIMER_WIDTH-1:0] lead_t, low_t, high_t, remain_dec;

    assign h1        = s_data[0];
    assign h2        = s_data[1];
    assign h3        = s_data[2];
    assign high_time = s_data[13:3];

    // Edges are handled in the order 1, 2, 3; each lookup sees the lines handled so far.
    always_comb begin
        e1   = h1 != hall_reg[2];
        pat1 = {h1, hall_reg[1:0]};
        lk1  = sector_lookup(dir_reg, pat1);
        sec1 = (e1 && lk1 != SECTOR_INVALID) ? lk1 : sector_reg;

        e2   = h2 != hall_reg[1];
        pat2 = {pat1[2], h2, pat1[0]};
        lk2  = sector_lookup(dir_reg, pat2);
        sec2 = (e2 && lk2 != SECTOR_INVALID) ? lk2 : sec1;

        e3   = h3 != hall_reg[0];
        pat3 = {pat2[2:1], h3};
        lk3  = sector_lookup(dir_reg, pat3);
        sec3 = (e3 && lk3 != SECTOR_INVALID) ? lk3 : sec2;

        any_edge = e1 || e2 || e3;
    end

    assign status.close_meas = e2 && meas_reg;

    // Net position step from rising edges on hall 1 and hall 3, in -2..2.
    always_comb begin
        pos_delta = 3'd0;
        if (e1 && h1) begin
            pos_delta = h2 ? 3'd1 : 3'b111;
        end
        if (e3 && h3) begin
            pos_delta = pos_delta + (h2 ? 3'b111 : 3'd1);
        end
    end

    always_comb begin
        lead_t     = TIMER_WIDTH'(lead_reg);
        low_t      = TIMER_WIDTH'(low_reg);
        high_t     = TIMER_WIDTH'(high_time);
        if (lead_t == '0) lead_t = TIMER_WIDTH'(1);
        if (low_t == '0)  low_t  = TIMER_WIDTH'(1);
        if (high_t == '0) high_t = TIMER_WIDTH'(1);
        remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;
        period_inc = (meas_reg && period_reg != '1) ? period_reg + 1'b1 : period_reg;
    end

    always_comb begin
        hall_next    = {h1, h2, h3};
        sector_next  = sec3;
        pos_next     = pos_reg + {{(POSITION_WIDTH - 3){pos_delta[2]}}, pos_delta};
        meas_next    = meas_reg;
        period_next  = period_inc;
        updated_next = 1'b0;
        if (e2) begin
            if (!meas_reg) begin
                period_next = '0;
                meas_next   = 1'b1;
            end else begin
                meas_next    = 1'b0;
                updated_next = 1'b1;
            end
        end
        phase_next  = phase_reg;
        remain_next = remain_dec;
        if (any_edge) begin
            phase_next  = PHASE_LEAD;
            remain_next = lead_t;
        end else if (remain_dec == '0) begin
            if (phase_reg == PHASE_DRIVE) begin
                phase_next  = PHASE_LOW;
                remain_next = low_t;
            end else begin
                phase_next  = PHASE_DRIVE;
                remain_next = high_t;
            end
        end
    end

    // One restoring step: shift in the next numerator bit, subtract when it fits.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIV_STEPS-1]};
        rem_diff  = CMPW'(rem_shift) - CMPW'(divisor_reg);
        rem_ge    = CMPW'(rem_shift) >= CMPW'(divisor_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg     <= 1'b0;
            lead_reg    <= LEAD_RESET;
            low_reg     <= LOW_RESET;
            ppr_reg     <= PPR_RESET;
            hall_reg    <= HALL_RESET;
            sector_reg  <= '0;
            phase_reg   <= PHASE_LEAD;
            remain_reg  <= TIMER_WIDTH'(LEAD_RESET);
            pos_reg     <= '0;
            meas_reg    <= 1'b0;
            period_reg  <= '0;
            updated_reg <= 1'b0;
            speed_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DIRECTION: dir_reg  <= cfg_data[0];
                    CFG_LEAD_TIME: lead_reg <= cfg_data[9:0];
                    CFG_LOW_TIME:  low_reg  <= cfg_data[15:0];
                    CFG_PULSES:    ppr_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                hall_reg    <= hall_next;
                sector_reg  <= sector_next;
                phase_reg   <= phase_next;
                remain_reg  <= remain_next;
                pos_reg     <= pos_next;
                meas_reg    <= meas_next;
                period_reg  <= period_next;
                updated_reg <= updated_next;
            end
            if (cmd.div_done) begin
                speed_reg <= (quo_reg > DIV_STEPS'(SPEED_MAX)) ? SPEED_MAX : quo_reg[24:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_div) begin
            divisor_reg <= DIVW'(period_reg) * DIVW'(ppr_reg);
            rem_reg     <= '0;
            quo_reg     <= SPEED_NUMERATOR;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? DIV_STEPS'(rem_diff) : DIV_STEPS'(rem_shift);
            quo_reg <= {quo_reg[DIV_STEPS-2:0], rem_ge};
        end
        if (cmd.emit) begin
            out_data_reg <= {4'd0, speed_reg, 32'(pos_reg), phase_reg, sector_reg,
                             (phase_reg == PHASE_DRIVE) ? drive_pattern(sector_reg)
                                                        : ALL_FLOAT};
            out_updated_reg <= updated_reg;
        end
    end

    assign out_data    = out_data_reg;
    assign out_updated = out_updated_reg;

endmodule

// ----- rtl/hall_six_step_commutator.sv -----
// Top level of the hall six-step commutator: stream ports, configuration port,
// controller and datapath. Depends on hssc_pkg, hssc_ctrl and hssc_datapath.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------------
//  input    | s_tvalid s_tready s_tdata      | one microsecond tick: halls, high time
//  result   | m_tvalid m_tready m_tdata/tuser| gates, sector, phase, position, speed
//  config   | cfg_we cfg_index cfg_data      | register write, no read-back
//
// A tick with no speed measurement closing goes from accept straight to the emit step.
// A tick that closes a measurement first runs one multiply, then the one-bit-per-cycle
// restoring divider, one step to saturate, then the emit step that loads the output.
// One tick is in work at a time; the next transfer is taken while a result waits.
// A stalled result holds in the output register and stalls only the next tick.
// Reset is synchronous on aresetn low and restores all settings and motor state.
module hall_six_step_commutator import hssc_pkg::*; #(
    parameter int POSITION_WIDTH = 32,
    parameter int PERIOD_WIDTH   = 32,
    parameter int TIMER_WIDTH    = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input ticks
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,  // hall_one, hall_two, hall_three, high_time_us[10:0], pad
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,  // gate_pins[5:0], sector[2:0], phase_mode[1:0],
                                             // position_count[31:0], speed_rpm_x10[24:0], pad
    output logic                   m_tuser   // speed_updated
);

    hssc_cmd_t    cmd;
    hssc_status_t status;

    // Sequence each tick: accept, optional speed division, then hand the result over.
    hssc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold settings and motor state; update the motor state on each accepted tick.
    hssc_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .PERIOD_WIDTH   (PERIOD_WIDTH),
        .TIMER_WIDTH    (TIMER_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_data      (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_data    (m_tdata),
        .out_updated (m_tuser)
    );

endmodule

// ----- rtl/hssc_checker.sv -----
// Port-level checker for the hall six-step commutator, bound to the top level.
// Depends on hssc_pkg and hall_six_step_commutator_defines.svh.
`include "hall_six_step_commutator_defines.svh"

module hssc_checker import hssc_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_DATA_W-1:0]  m_tdata,
    input logic                   m_tuser
);

    logic                  stalled;
    logic [OUT_DATA_W:0]   result_word;
    logic [5:0]            gates_seen;
    logic [2:0]            sector_seen;
    logic [1:0]            phase_seen;
    logic                  idle_result;
    logic                  pair_ok;

    assign stalled     = m_tvalid && !m_tready;
    assign result_word = {m_tuser, m_tdata};
    assign gates_seen  = m_tdata[5:0];
    assign sector_seen = m_tdata[8:6];
    assign phase_seen  = m_tdata[10:9];
    assign idle_result = m_tvalid && (phase_seen != PHASE_DRIVE);
    assign pair_ok     = (gates_seen[5:4] != 2'b01) && (gates_seen[3:2] != 2'b01) &&
                         (gates_seen[1:0] != 2'b01);

    // A stalled result holds.
    `HSSC_ASSERT_NEXT(a_result_holds, stalled, m_tvalid && $stable(result_word), "result changed")

    // One tick in work at a time.
    `HSSC_ASSERT_NEXT(a_one_tick, s_tvalid && s_tready, !s_tready, "second tick taken while busy")

    // Outside the drive interval all phases float.
    `HSSC_ASSERT_NOW(a_float_when_idle, idle_result, gates_seen == ALL_FLOAT, "gates not floating")

    // No half bridge ever shows the shoot-through code.
    `HSSC_ASSERT_NOW(a_no_bad_pair, m_tvalid, pair_ok, "illegal gate pair")

    // The sector stays within the six-step range.
    `HSSC_ASSERT_NOW(a_sector_range, m_tvalid, sector_seen < 3'd6, "sector out of range")

endmodule

bind hall_six_step_commutator hssc_checker u_checker (.*);
